@@ rtl/core/rd_pkg.sv @@
// Shared types and constants for the rotating deque.
// Opcode and status codes, field widths and the per-cell control word.
// No dependencies.
package rd_pkg;

   localparam int OPCODE_BITS = 3;
   localparam int VALUE_BITS  = 32;
   localparam int COUNT_BITS  = 16;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_STEP_BITS = $clog2(COUNT_BITS + 1);

   typedef logic [OPCODE_BITS-1:0]        opcode_type;
   typedef logic signed [VALUE_BITS-1:0]  value_type;
   typedef logic [COUNT_BITS-1:0]         count_type;
   typedef logic [STATUS_BITS-1:0]        status_type;

   localparam opcode_type OP_PUSH_FRONT = 3'd0;
   localparam opcode_type OP_PUSH_BACK  = 3'd1;
   localparam opcode_type OP_POP_FRONT  = 3'd2;
   localparam opcode_type OP_POP_BACK   = 3'd3;
   localparam opcode_type OP_ROT_LEFT   = 3'd4;
   localparam opcode_type OP_ROT_RIGHT  = 3'd5;
   localparam opcode_type OP_READOUT    = 3'd6;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_EMPTY     = 2'd1;
   localparam status_type ST_FULL      = 2'd2;
   localparam status_type ST_BAD_COUNT = 2'd3;

   // Per-cell load selects; wrap takes the front cell instead of the right neighbor.
   typedef struct packed {
      logic take_value;
      logic take_left;
      logic take_right;
      logic wrap;
   } cell_ctrl_type;

endpackage

@@ rtl/core/rd_channels.sv @@
// Request and response channel interfaces for the rotating deque.
// Valid/ready handshake with payload; depends on rd_pkg.
interface rd_req_if
   import rd_pkg::*;
();
   logic       valid;
   logic       ready;
   opcode_type opcode;
   value_type  value;
   count_type  rotate_count;

   modport source (output valid, output opcode, output value, output rotate_count,
                   input ready);
   modport sink   (input valid, input opcode, input value, input rotate_count,
                   output ready);
endinterface

interface rd_rsp_if
   import rd_pkg::*;
();
   logic       valid;
   logic       ready;
   value_type  element;
   status_type status;
   logic       last;

   modport source (output valid, output element, output status, output last,
                   input ready);
   modport sink   (input valid, input element, input status, input last,
                   output ready);
endinterface

@@ rtl/core/rd_cell.sv @@
// One storage cell of the deque chain: holds one element and loads from
// its left neighbor, right neighbor, the front cell or the pushed value.
// Depends on rd_pkg.
module rd_cell
   import rd_pkg::*;
#(
   parameter int DATA_BITS = 32
) (
   input  logic                        clock,
   input  cell_ctrl_type               ctrl,
   input  logic signed [DATA_BITS-1:0] left_in,
   input  logic signed [DATA_BITS-1:0] right_in,
   input  logic signed [DATA_BITS-1:0] front_in,
   input  logic signed [DATA_BITS-1:0] value_in,
   output logic signed [DATA_BITS-1:0] q
);

   logic signed [DATA_BITS-1:0] data_ff;
   logic signed [DATA_BITS-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.take_value) begin
         data_in = value_in;
      end else if (ctrl.take_left) begin
         data_in = left_in;
      end else if (ctrl.take_right) begin
         data_in = ctrl.wrap ? front_in : right_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;

endmodule

@@ rtl/core/rd_modulo.sv @@
// Bit-serial remainder unit: count modulo list length, one dividend bit per
// cycle. Depends on rd_pkg.
module rd_modulo
   import rd_pkg::*;
#(
   parameter int LEN_BITS = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  count_type           dividend,
   input  logic [LEN_BITS-1:0] divisor,
   output logic                done,
   output logic [LEN_BITS-1:0] remainder
);

   logic                       busy_ff,  busy_in;
   logic                       done_ff,  done_in;
   logic [COUNT_STEP_BITS-1:0] bits_ff,  bits_in;
   count_type                  shift_ff, shift_in;
   logic [LEN_BITS-1:0]        rem_ff,   rem_in;
   logic [LEN_BITS:0]          trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      bits_in  = bits_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      trial    = {rem_ff, shift_ff[COUNT_BITS-1]};
      if (start) begin
         busy_in  = 1'b1;
         bits_in  = COUNT_STEP_BITS'(COUNT_BITS);
         shift_in = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         // restoring step: remainder stays below divisor
         if (trial >= {1'b0, divisor}) begin
            rem_in = LEN_BITS'(trial - {1'b0, divisor});
         end else begin
            rem_in = LEN_BITS'(trial);
         end
         shift_in = shift_ff << 1;
         bits_in  = bits_ff - 1'b1;
         if (bits_ff == COUNT_STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         bits_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         bits_ff <= bits_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/core/rotating_deque.sv @@
// Rotating deque: a chain of CAPACITY cells, cell 0 the front, with a length count.
// Push/pop: request taken in S_IDLE, result registered from S_EXEC once the output is free.
// Readout: S_STREAM emits L elements, one element per cycle while the output is not stalled.
// Rotate: S_MOD runs the serial remainder, S_ROT does s chain steps, S_STREAM emits L.
// Synchronous active-high reset empties the list; cell contents are not cleared.
// Depends on rd_pkg, rd_channels, rd_cell, rd_modulo.
module rotating_deque
   import rd_pkg::*;
#(
   parameter int CAPACITY  = 16,
   parameter int DATA_BITS = 32
) (
   input  logic     clock,
   input  logic     reset,
   rd_req_if.sink   req_bus,
   rd_rsp_if.source rsp_bus
);

   localparam int LEN_BITS = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_MOD,
      S_ROT,
      S_STREAM
   } fsm_state_type;

   fsm_state_type       state_ff, state_in;
   opcode_type          op_ff, op_in;
   value_type           value_ff, value_in;
   count_type           count_ff, count_in;
   logic [LEN_BITS-1:0] length_ff, length_in;
   logic [LEN_BITS-1:0] steps_ff, steps_in;
   logic                out_valid_ff, out_valid_in;
   value_type           out_element_ff, out_element_in;
   status_type          out_status_ff, out_status_in;
   logic                out_last_ff, out_last_in;

   logic                push_front;
   logic                push_back;
   logic                shift_left;
   logic                mod_start;
   logic                mod_done;
   logic [LEN_BITS-1:0] mod_rem;
   logic [LEN_BITS-1:0] rot_steps;
   logic                out_free;
   logic                is_empty;
   logic                is_full;

   logic signed [DATA_BITS-1:0] store_val;
   logic signed [DATA_BITS-1:0] cell_q [CAPACITY];
   value_type                   front_val;

   assign store_val = DATA_BITS'(value_ff);
   assign front_val = VALUE_BITS'(cell_q[0]);
   assign out_free  = !out_valid_ff || rsp_bus.ready;
   assign is_empty  = (length_ff == '0);
   assign is_full   = (length_ff == LEN_BITS'(CAPACITY));

   always_comb begin
      if (op_ff == OP_ROT_LEFT) begin
         rot_steps = mod_rem;
      end else if (mod_rem == '0) begin
         rot_steps = '0;
      end else begin
         rot_steps = length_ff - mod_rem;
      end
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      value_in       = value_ff;
      count_in       = count_ff;
      length_in      = length_ff;
      steps_in       = steps_ff;
      out_valid_in   = out_valid_ff && !rsp_bus.ready;
      out_element_in = out_element_ff;
      out_status_in  = out_status_ff;
      out_last_in    = out_last_ff;
      push_front     = 1'b0;
      push_back      = 1'b0;
      shift_left     = 1'b0;
      mod_start      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in    = req_bus.opcode;
               value_in = req_bus.value;
               count_in = req_bus.rotate_count;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in       = S_IDLE;
               out_element_in = '0;
               out_status_in  = ST_OK;
               out_last_in    = 1'b1;
               case (op_ff) inside
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     out_valid_in = 1'b1;
                     if (is_full) begin
                        out_status_in = ST_FULL;
                     end else begin
                        push_front = (op_ff == OP_PUSH_FRONT);
                        push_back  = (op_ff == OP_PUSH_BACK);
                        length_in  = length_ff + 1'b1;
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK: begin
                     out_valid_in = 1'b1;
                     if (is_empty) begin
                        out_status_in = ST_EMPTY;
                     end else begin
                        shift_left = (op_ff == OP_POP_FRONT);
                        length_in  = length_ff - 1'b1;
                     end
                  end
                  OP_ROT_LEFT, OP_ROT_RIGHT: begin
                     if (is_empty) begin
                        out_valid_in  = 1'b1;
                        out_status_in = ST_EMPTY;
                     end else if (count_ff == '0) begin
                        out_valid_in  = 1'b1;
                        out_status_in = ST_BAD_COUNT;
                     end else begin
                        mod_start = 1'b1;
                        state_in  = S_MOD;
                     end
                  end
                  OP_READOUT: begin
                     if (is_empty) begin
                        out_valid_in  = 1'b1;
                        out_status_in = ST_EMPTY;
                     end else begin
                        steps_in = length_ff;
                        state_in = S_STREAM;
                     end
                  end
                  default: begin
                     // unused opcode: drop silently
                  end
               endcase
            end
         end
         S_MOD: begin
            if (mod_done) begin
               if (rot_steps == '0) begin
                  steps_in = length_ff;
                  state_in = S_STREAM;
               end else begin
                  steps_in = rot_steps;
                  state_in = S_ROT;
               end
            end
         end
         S_ROT: begin
            shift_left = 1'b1;
            steps_in   = steps_ff - 1'b1;
            if (steps_ff == LEN_BITS'(1)) begin
               steps_in = length_ff;
               state_in = S_STREAM;
            end
         end
         S_STREAM: begin
            if (out_free) begin
               // emit the front and rotate it to the back
               out_valid_in   = 1'b1;
               out_element_in = front_val;
               out_status_in  = ST_OK;
               out_last_in    = (steps_ff == LEN_BITS'(1));
               shift_left     = 1'b1;
               steps_in       = steps_ff - 1'b1;
               if (steps_ff == LEN_BITS'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         length_ff    <= '0;
         steps_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         steps_ff     <= steps_in;
         out_valid_ff <= out_valid_in;
      end
      op_ff          <= op_in;
      value_ff       <= value_in;
      count_ff       <= count_in;
      out_element_ff <= out_element_in;
      out_status_ff  <= out_status_in;
      out_last_ff    <= out_last_in;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_BITS-1:0] left_data;
      logic signed [DATA_BITS-1:0] right_data;
      cell_ctrl_type               ctrl;

      if (i == 0) begin : g_first
         assign left_data = store_val;
      end else begin : g_mid_left
         assign left_data = cell_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = cell_q[0];
      end else begin : g_mid_right
         assign right_data = cell_q[i+1];
      end

      assign ctrl.take_value = push_back && (length_ff == LEN_BITS'(i));
      assign ctrl.take_left  = push_front;
      assign ctrl.take_right = shift_left;
      assign ctrl.wrap       = (length_ff == LEN_BITS'(i + 1));

      rd_cell #(
         .DATA_BITS (DATA_BITS)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .left_in  (left_data),
         .right_in (right_data),
         .front_in (cell_q[0]),
         .value_in (store_val),
         .q        (cell_q[i])
      );
   end

   rd_modulo #(
      .LEN_BITS (LEN_BITS)
   ) u_modulo (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (count_ff),
      .divisor   (length_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign req_bus.ready   = (state_ff == S_IDLE);
   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.element = out_element_ff;
   assign rsp_bus.status  = out_status_ff;
   assign rsp_bus.last    = out_last_ff;

endmodule

@@ rtl/core/rd_checker.sv @@
// Port-level checks for the rotating deque, bound to the top level.
// Depends on rd_pkg and rotating_deque.
module rd_checker
   import rd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input value_type  rsp_element,
   input status_type rsp_status,
   input logic       rsp_last
);

   // hold a stalled response
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_element) && $stable(rsp_status)
                                  && $stable(rsp_last))
      else $error("response payload changed while stalled");

   // error responses stand alone and carry no element
   a_err_alone : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_last && rsp_element == '0)
      else $error("error response not final or element not zero");

   // no new request while a stream is still running
   a_stream_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken in the middle of a stream");

endmodule

bind rotating_deque rd_checker u_rd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_element (rsp_bus.element),
   .rsp_status  (rsp_bus.status),
   .rsp_last    (rsp_bus.last)
);
